// File: rtl/psx_controller_poll_master_unit_macros.svh
// Assertion macros shared by the controller poll master RTL.
`ifndef PSX_CONTROLLER_POLL_MASTER_UNIT_MACROS_SVH
`define PSX_CONTROLLER_POLL_MASTER_UNIT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define PSX_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define PSX_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/psx_pm_pkg.sv
// Shared types, constants and helper functions of the controller poll master.
package psx_pm_pkg;

    // Number of bytes in one poll exchange and the index of the last one.
    localparam int POLL_BYTES = 5;
    localparam logic [2:0] LAST_BYTE = 3'(POLL_BYTES - 1);
    // Byte whose reply carries the first button group.
    localparam logic [2:0] FIRST_REPLY_BYTE = 3'd3;
    // Reset value of the inter-byte delay register.
    localparam logic [7:0] DELAY_RESET = 8'd10;

    // One result word as produced for each tick.
    typedef struct packed {
        logic       att;
        logic       clk;
        logic       cmd;
        logic       done;
        logic [9:0] buttons;
        logic [3:0] dpad;
    } t_result;

    // Command byte sent in each slot of the exchange.
    function automatic logic [7:0] poll_cmd(input logic [2:0] byte_num);
        logic [7:0] cmd_byte;
        case (byte_num)
            3'd0:    cmd_byte = 8'h01;
            3'd1:    cmd_byte = 8'h42;
            default: cmd_byte = 8'h00;
        endcase
        return cmd_byte;
    endfunction

    // Inverts and remaps the two button replies: buttons in bits 0-9, dpad in 10-13.
    function automatic logic [13:0] decode_buttons(input logic [7:0] a1,
                                                   input logic [7:0] a2);
        logic [13:0] btn;
        btn[0]  = ~a2[6];
        btn[1]  = ~a2[5];
        btn[2]  = ~a2[7];
        btn[3]  = ~a2[4];
        btn[4]  = ~a2[2];
        btn[5]  = ~a2[3];
        btn[6]  = ~a2[0];
        btn[7]  = ~a2[1];
        btn[8]  = ~a1[0];
        btn[9]  = ~a1[3];
        btn[10] = ~a1[4];
        btn[11] = ~a1[5];
        btn[12] = ~a1[6];
        btn[13] = ~a1[7];
        return btn;
    endfunction

endpackage

// File: rtl/psx_pm_engine.sv
// Poll sequencer: protocol state, delay register and per-tick result logic.
`include "psx_controller_poll_master_unit_macros.svh"

module psx_pm_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_step,
    input  logic                i_start,
    input  logic                i_data,
    output psx_pm_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DELAY = 3'd1,
        PH_BIT   = 3'd2
    } t_phase;

    logic [7:0]  r_delay;
    t_phase      r_phase, n_phase;
    logic [2:0]  r_byte, n_byte;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_tick, n_tick;
    logic [7:0]  r_tx, n_tx;
    logic [7:0]  r_rx, n_rx;
    logic [7:0]  r_first, n_first;
    logic [13:0] r_held, n_held;

    logic       w_begin;
    logic [2:0] w_begin_byte;
    logic [7:0] w_tick_inc;
    logic [7:0] w_rx_shift;
    logic [2:0] w_bit_inc;
    logic       w_att, w_clk, w_cmd, w_done;

    assign w_tick_inc = r_tick + 8'd1;
    assign w_rx_shift = {i_data, r_rx[7:1]};
    assign w_bit_inc  = r_bit + 3'd1;

    // Next state and line levels for the current tick.
    always_comb begin
        n_phase      = r_phase;
        n_byte       = r_byte;
        n_bit        = r_bit;
        n_tick       = r_tick;
        n_tx         = r_tx;
        n_rx         = r_rx;
        n_first      = r_first;
        n_held       = r_held;
        w_att        = 1'b1;
        w_clk        = 1'b1;
        w_cmd        = 1'b0;
        w_done       = 1'b0;
        w_begin      = 1'b0;
        w_begin_byte = 3'd0;
        unique case (r_phase)
            PH_DELAY: begin
                w_att = 1'b0;
                if (w_tick_inc >= r_delay) begin
                    n_phase = PH_BIT;
                    n_tick  = 8'd0;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            PH_BIT: begin
                w_att = 1'b0;
                w_clk = r_tick[1];
                w_cmd = r_tx[0];
                if (r_tick[1:0] == 2'd3) begin
                    n_rx   = w_rx_shift;
                    n_tx   = {1'b0, r_tx[7:1]};
                    n_bit  = w_bit_inc;
                    n_tick = 8'd0;
                    if (w_bit_inc == 3'd0) begin
                        if (r_byte == psx_pm_pkg::FIRST_REPLY_BYTE) begin
                            n_first = w_rx_shift;
                        end
                        if (r_byte >= psx_pm_pkg::LAST_BYTE) begin
                            n_held  = psx_pm_pkg::decode_buttons(r_first, w_rx_shift);
                            w_done  = 1'b1;
                            n_phase = PH_IDLE;
                            n_byte  = 3'd0;
                        end else begin
                            w_begin      = 1'b1;
                            w_begin_byte = r_byte + 3'd1;
                        end
                    end
                end else begin
                    n_tick = {6'd0, r_tick[1:0] + 2'd1};
                end
            end
            default: begin
                // Idle, and any code without meaning behaves as idle.
                n_phase = PH_IDLE;
                if (i_start) begin
                    w_att        = 1'b0;
                    w_begin      = 1'b1;
                    w_begin_byte = 3'd0;
                end
            end
        endcase

        // Load the next command byte and start its delay or its first bit.
        if (w_begin) begin
            n_byte  = w_begin_byte;
            n_tx    = psx_pm_pkg::poll_cmd(w_begin_byte);
            n_rx    = 8'd0;
            n_bit   = 3'd0;
            n_tick  = 8'd0;
            n_phase = (r_delay == 8'd0) ? PH_BIT : PH_DELAY;
        end
    end

    assign o_res.att     = w_att;
    assign o_res.clk     = w_clk;
    assign o_res.cmd     = w_cmd;
    assign o_res.done    = w_done;
    assign o_res.buttons = n_held[9:0];
    assign o_res.dpad    = n_held[13:10];

    // Delay register, written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= psx_pm_pkg::DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_wdata;
        end
    end

    // Protocol state advances once for each tick word taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_byte  <= 3'd0;
            r_bit   <= 3'd0;
            r_tick  <= 8'd0;
            r_tx    <= 8'd0;
            r_rx    <= 8'd0;
            r_first <= 8'hFF;
            r_held  <= 14'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_byte  <= n_byte;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_tx    <= n_tx;
            r_rx    <= n_rx;
            r_first <= n_first;
            r_held  <= n_held;
        end
    end

    // The state only moves when a tick word is processed.
    `PSX_ASSERT_NEXT(a_hold_without_step, i_clk, i_rst_n, !i_step,
        $stable(r_phase) && $stable(r_byte) && $stable(r_tick), "state moved without a tick")
    // A finished poll leaves the sequencer idle at the first byte.
    `PSX_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n, i_step && w_done,
        r_phase == PH_IDLE && r_byte == 3'd0, "poll did not return to idle")
    // Within a bit the tick counter only walks the four bit ticks.
    `PSX_ASSERT_SAME(a_bit_tick_range, i_clk, i_rst_n, r_phase == PH_BIT,
        r_tick < 8'd4, "bit tick counter out of range")
    // Attention is low whenever the serial clock is driven low.
    `PSX_ASSERT_SAME(a_clock_under_att, i_clk, i_rst_n, !w_clk,
        !w_att, "clock low while attention high")

endmodule

// File: rtl/psx_controller_poll_master_unit.sv
// Top level of the controller poll master: tick stream in, line levels out.
//
// Each word on the slave channel is one 1-microsecond tick: bit 0 requests a
// poll, bit 1 is the sampled controller data line. For every word taken, one
// word leaves on the master channel with the attention, clock and command
// levels for that tick and the buttons of the last completed poll; tlast
// marks the tick on which a poll finishes.
// A word is taken in every cycle while the output side keeps up. The result
// word passes through one input register and then one result register before
// it is presented. The sequencer updates its state in a single pass between
// those two registers.
// If the receiver stalls, the result register holds its word and the input
// register takes one more word, then tready drops until the result leaves.
// The user must write the delay register through i_cfg_we/i_cfg_wdata only
// while idle; the block does not enforce this. Reset empties both registers,
// clears the sequencer and held buttons and sets the delay to ten ticks.
module psx_controller_poll_master_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: start_req, data_level, zero fill.
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: attention_level, clock_level, command_level,
    // buttons[9:0], dpad[3:0], zero fill.
    output logic [23:0] m_axis_tdata,
    // done_res: high on the tick that completes a poll.
    output logic        m_axis_tlast
);

    logic                r_in_valid;
    logic                r_in_start;
    logic                r_in_data;
    logic                r_out_valid;
    psx_pm_pkg::t_result r_out;
    psx_pm_pkg::t_result w_res;
    logic                w_fire;

    // A held tick moves on when the result register is free or draining.
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    psx_pm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_fire),
        .i_start     (r_in_start),
        .i_data      (r_in_data),
        .o_res       (w_res)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the input and result registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_start <= s_axis_tdata[0];
            r_in_data  <= s_axis_tdata[1];
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.dpad, r_out.buttons, r_out.cmd, r_out.clk, r_out.att};
    assign m_axis_tlast  = r_out.done;

endmodule
